// ===== hw/rtl/pgalloc_pkg.sv =====
// Shared types and constants of the first-fit page run allocator.
// Used by pgalloc_mem, pgalloc_unit, pgalloc_seq and the top level; depends on nothing.
package pgalloc_pkg;

   // field widths of one input item and one result item
   localparam int ACTION_W   = 3;
   localparam int PID_W      = 3;
   localparam int SIZE_W     = 22;
   localparam int VADDR_W    = 21;
   localparam int PADDR_W    = 36;
   localparam int ATTR_W     = 12;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 24;

   // page geometry
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_NUM_W = VADDR_W - PAGE_SHIFT;
   localparam int NPG_W      = SIZE_W + 1 - PAGE_SHIFT;

   // default sizing
   localparam int DEF_NUM_PROCS         = 8;
   localparam int DEF_ENTRIES_PER_TABLE = 512;

   localparam logic [PADDR_W-1:0] PHYS_BASE_RESET = 36'h0_0020_0000;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_MAP   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_UNMAP = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_SETUP,
      ST_REDUCE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   // what value the entry unit produces for a write
   typedef enum logic [1:0] {
      EK_ZERO,
      EK_ALLOC,
      EK_MAP
   } entry_kind_type;

   // table memory command from the sequencer
   typedef struct packed {
      logic we;
      logic re;
   } mem_ctl_type;

endpackage

// ===== hw/rtl/pgalloc_mem.sv =====
// Page table occupancy memory: one bit per entry, set when the entry is nonzero.
// One address port, registered read. Depends on pgalloc_pkg.
module pgalloc_mem #(
   parameter int DEPTH = pgalloc_pkg::DEF_NUM_PROCS * pgalloc_pkg::DEF_ENTRIES_PER_TABLE,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  pgalloc_pkg::mem_ctl_type mem_ctl,
   input  logic [ADDR_W-1:0]        mem_addr,
   input  logic                     mem_wbit,
   output logic                     mem_rdata
);
   import pgalloc_pkg::*;

   logic used_ff [DEPTH];
   logic rdata_ff;

   // write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (mem_ctl.we) begin
         used_ff[mem_addr] <= mem_wbit;
      end
      if (mem_ctl.re) begin
         rdata_ff <= used_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ===== hw/rtl/pgalloc_unit.sv =====
// Entry value unit: forms the 36-bit entry for an alloc or map write and
// tells whether it is nonzero. Depends on pgalloc_pkg.
module pgalloc_unit #(
   parameter int ENTRIES_PER_TABLE = pgalloc_pkg::DEF_ENTRIES_PER_TABLE,
   parameter int IDX_W = $clog2(ENTRIES_PER_TABLE)
) (
   input  pgalloc_pkg::entry_kind_type                 kind,
   input  logic [IDX_W-1:0]                            idx,
   input  logic [pgalloc_pkg::PADDR_W-1:0]             phys_base,
   input  logic [pgalloc_pkg::PADDR_W-1:0]             paddr,
   input  logic [pgalloc_pkg::ATTR_W-1:0]              attr,
   output logic                                        busy
);
   import pgalloc_pkg::*;

   logic [PADDR_W-1:0] alloc_val;
   logic [PADDR_W-1:0] map_val;

   // base plus page offset, wrapping at 36 bits, then attributes
   assign alloc_val = (phys_base + PADDR_W'({idx, {PAGE_SHIFT{1'b0}}})) | PADDR_W'(attr);
   assign map_val   = {paddr[PADDR_W-1:PAGE_SHIFT], attr};

   // pick the value kind and test for zero
   always_comb begin
      unique case (kind)
         EK_ALLOC: busy = |alloc_val;
         EK_MAP:   busy = |map_val;
         EK_ZERO:  busy = 1'b0;
         default:  busy = 1'b0;
      endcase
   end

endmodule

// ===== hw/rtl/pgalloc_seq.sv =====
// Sequencer of the page run allocator: item capture, wipe pass, first-fit scan,
// run writes and the result register. Depends on pgalloc_pkg.
module pgalloc_seq #(
   parameter int NUM_PROCS = pgalloc_pkg::DEF_NUM_PROCS,
   parameter int ENTRIES_PER_TABLE = pgalloc_pkg::DEF_ENTRIES_PER_TABLE,
   parameter int ADDR_W = $clog2(NUM_PROCS * ENTRIES_PER_TABLE),
   parameter int IDX_W = $clog2(ENTRIES_PER_TABLE)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // item in
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pgalloc_pkg::ACTION_W-1:0]     req_action,
   input  logic [pgalloc_pkg::PID_W-1:0]        req_pid,
   input  logic [pgalloc_pkg::SIZE_W-1:0]       req_size,
   input  logic [pgalloc_pkg::VADDR_W-1:0]      req_vaddr,
   input  logic [pgalloc_pkg::PADDR_W-1:0]      req_paddr,
   input  logic [pgalloc_pkg::ATTR_W-1:0]       req_attr,
   // table memory
   output pgalloc_pkg::mem_ctl_type             mem_ctl,
   output logic [ADDR_W-1:0]                    mem_addr,
   output logic                                 mem_wbit,
   input  logic                                 mem_rdata,
   // entry unit
   output pgalloc_pkg::entry_kind_type          unit_kind,
   output logic [IDX_W-1:0]                     unit_idx,
   output logic [pgalloc_pkg::PADDR_W-1:0]      unit_paddr,
   output logic [pgalloc_pkg::ATTR_W-1:0]       unit_attr,
   input  logic                                 unit_busy,
   // result out
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pgalloc_pkg::VADDR_W-1:0]      rsp_vaddr,
   output logic                                 rsp_status
);
   import pgalloc_pkg::*;

   localparam int MEM_DEPTH = NUM_PROCS * ENTRIES_PER_TABLE;
   localparam int CNT_W = $clog2(ENTRIES_PER_TABLE + 1);
   localparam int WRK_W = (CNT_W > PAGE_NUM_W) ? CNT_W : PAGE_NUM_W;
   localparam int REM_W = (CNT_W > NPG_W) ? CNT_W : NPG_W;
   localparam int CMP_W = REM_W + 1;
   localparam logic [WRK_W-1:0]  ENT_WRK   = WRK_W'(ENTRIES_PER_TABLE);
   localparam logic [CNT_W-1:0]  ENT_CNT   = CNT_W'(ENTRIES_PER_TABLE);
   localparam logic [REM_W-1:0]  ENT_REM   = REM_W'(ENTRIES_PER_TABLE);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES_PER_TABLE - 1);
   localparam logic [ADDR_W-1:0] ENT_ADDR  = ADDR_W'(ENTRIES_PER_TABLE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

   // captured item
   logic [ACTION_W-1:0] act_ff;
   logic                pid_ok_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [NPG_W-1:0]    npg_ff;
   logic [PADDR_W-1:0]  paddr_ff;
   logic [ATTR_W-1:0]   attr_ff;

   // control
   state_type           state_ff, state_in;
   entry_kind_type      kind_ff, kind_in;
   logic [ADDR_W-1:0]   wipe_ff, wipe_in;
   logic [WRK_W-1:0]    pg_ff, pg_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [VADDR_W-1:0]  res_vaddr_ff, res_vaddr_in;
   logic                res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VADDR_W-1:0]  rsp_vaddr_ff, rsp_vaddr_in;
   logic                rsp_status_ff, rsp_status_in;

   logic [SIZE_W:0]     size_sum;
   logic [CMP_W-1:0]    run_inc;
   logic [CMP_W-1:0]    start_cmp;
   logic [IDX_W-1:0]    start_idx;
   logic                found;

   // capture the item on accept
   assign size_sum = {1'b0, req_size} + (SIZE_W + 1)'((1 << PAGE_SHIFT) - 1);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff    <= req_action;
         pid_ok_ff <= ({{(32 - PID_W){1'b0}}, req_pid} < 32'(NUM_PROCS));
         base_ff   <= ADDR_W'(req_pid) * ENT_ADDR;
         npg_ff    <= size_sum[SIZE_W:PAGE_SHIFT];
         pg_ff     <= WRK_W'(req_vaddr[VADDR_W-1:PAGE_SHIFT]);
         paddr_ff  <= req_paddr;
         attr_ff   <= req_attr;
      end else begin
         pg_ff     <= pg_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         kind_ff      <= EK_ZERO;
         wipe_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         wipe_ff      <= wipe_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      rem_ff        <= rem_in;
      run_ff        <= run_in;
      rd_idx_ff     <= rd_idx_in;
      res_vaddr_ff  <= res_vaddr_in;
      res_status_ff <= res_status_in;
      rsp_vaddr_ff  <= rsp_vaddr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // start index of a run that ends at the entry just read
   assign run_inc   = CMP_W'(run_ff) + CMP_W'(1);
   assign start_cmp = CMP_W'(rd_idx_ff) + CMP_W'(1) - CMP_W'(npg_ff);
   assign start_idx = start_cmp[IDX_W-1:0];

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      wipe_in       = wipe_ff;
      pg_in         = pg_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      run_in        = run_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      res_vaddr_in  = res_vaddr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_vaddr_in  = rsp_vaddr_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl       = '0;
      req_ready     = 1'b0;
      found         = 1'b0;

      unique case (state_ff)
         // zero every entry once after reset
         ST_WIPE: begin
            mem_ctl.we = 1'b1;
            kind_in    = EK_ZERO;
            wipe_in    = wipe_ff + ADDR_W'(1);
            if (wipe_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            res_vaddr_in  = '0;
            res_status_in = 1'b0;
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         // dispatch on the action
         ST_SETUP: begin
            k_in   = '0;
            run_in = '0;
            if (!pid_ok_ff) begin
               res_status_in = (act_ff == ACT_ALLOC);
               state_in      = ST_DONE;
            end else begin
               case (act_ff)
                  ACT_ALLOC: begin
                     kind_in  = EK_ALLOC;
                     state_in = (npg_ff == '0) ? ST_DONE : ST_SCAN;
                  end
                  ACT_FREE: begin
                     kind_in  = EK_ZERO;
                     rem_in   = REM_W'(npg_ff);
                     state_in = (npg_ff == '0) ? ST_DONE : ST_REDUCE;
                  end
                  ACT_MAP: begin
                     kind_in  = EK_MAP;
                     rem_in   = REM_W'(1);
                     state_in = ST_REDUCE;
                  end
                  ACT_UNMAP: begin
                     kind_in  = EK_ZERO;
                     rem_in   = REM_W'(1);
                     state_in = ST_REDUCE;
                  end
                  ACT_CLEAR: begin
                     kind_in  = EK_ZERO;
                     rem_in   = ENT_REM;
                     state_in = ST_WRITE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // fold the page number into the table, one subtract a cycle
         ST_REDUCE: begin
            if (pg_ff >= ENT_WRK) begin
               pg_in = pg_ff - ENT_WRK;
            end else begin
               k_in     = CNT_W'(pg_ff);
               state_in = ST_WRITE;
            end
         end
         // issue one read a cycle, count the free run on returned data
         ST_SCAN: begin
            if (k_ff < ENT_CNT) begin
               mem_ctl.re = 1'b1;
               k_in       = k_ff + CNT_W'(1);
               rd_vld_in  = 1'b1;
               rd_idx_in  = k_ff[IDX_W-1:0];
            end
            if (rd_vld_ff) begin
               if (mem_rdata) begin
                  run_in = '0;
               end else begin
                  run_in = run_inc[CNT_W-1:0];
                  if (run_inc == CMP_W'(npg_ff)) begin
                     found        = 1'b1;
                     k_in         = CNT_W'(start_idx);
                     rem_in       = REM_W'(npg_ff);
                     rd_vld_in    = 1'b0;
                     res_vaddr_in = VADDR_W'({start_idx, {PAGE_SHIFT{1'b0}}});
                     state_in     = ST_WRITE;
                  end
               end
               if (!found && rd_idx_ff == LAST_IDX) begin
                  rd_vld_in     = 1'b0;
                  res_status_in = 1'b1;
                  state_in      = ST_DONE;
               end
            end
         end
         // write one entry a cycle until the run or the table ends
         ST_WRITE: begin
            mem_ctl.we = 1'b1;
            if (rem_ff == REM_W'(1) || k_ff[IDX_W-1:0] == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               k_in   = k_ff + CNT_W'(1);
               rem_in = rem_ff - REM_W'(1);
            end
         end
         // hand the item to the result register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_vaddr_in  = res_vaddr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory address and write data
   assign mem_addr = (state_ff == ST_WIPE) ? wipe_ff
                                           : base_ff + ADDR_W'(k_ff[IDX_W-1:0]);
   assign mem_wbit = unit_busy;

   assign unit_kind  = kind_ff;
   assign unit_idx   = k_ff[IDX_W-1:0];
   assign unit_paddr = paddr_ff;
   assign unit_attr  = attr_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vaddr  = rsp_vaddr_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hw/rtl/page_run_first_fit_allocator.sv =====
// Top level of the first-fit page run allocator: stream ports, phys_base register,
// assertions. Instantiates pgalloc_seq, pgalloc_unit and pgalloc_mem; uses pgalloc_pkg.
//
//   channel  | ports              | moves
//   ---------+--------------------+---------------------------------------------
//   request  | req_t*             | one item: action, pid, size, vaddr, paddr, attr
//   response | rsp_t*             | one item per request: alloc vaddr, status
//   csr      | csr_we, csr_wdata  | phys_base write
//
// After reset a wipe pass over all NUM_PROCS*ENTRIES_PER_TABLE entries (4096 by default)
// zeroes the table memory with req_tready low; csr writes are taken during it.
// The table memory port reads or writes one entry a cycle and sets the item time:
// alloc scans the table until a free run is found, then writes one entry per page,
// clear writes every entry of the table, free one entry per page up to the table end,
// map and unmap one entry (page index folding adds to this below 512 entries a table).
// One item is in work at a time; the next is taken while a result waits in rsp.
module page_run_first_fit_allocator #(
   parameter int NUM_PROCS = pgalloc_pkg::DEF_NUM_PROCS,
   parameter int ENTRIES_PER_TABLE = pgalloc_pkg::DEF_ENTRIES_PER_TABLE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: tuser = action[2:0]
   // tdata = pid[2:0], size_bytes[24:3], virt_addr[45:25], phys_addr[81:46],
   //         attr_bits[93:82], zero fill[95:94]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [pgalloc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [pgalloc_pkg::ACTION_W-1:0]      req_tuser,
   // response: tdata = alloc_vaddr[20:0], zero fill[23:21]; tuser = status
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pgalloc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                  rsp_tuser,
   // phys_base register
   input  logic                                  csr_we,
   input  logic [pgalloc_pkg::PADDR_W-1:0]       csr_wdata
);
   import pgalloc_pkg::*;

   localparam int MEM_DEPTH = NUM_PROCS * ENTRIES_PER_TABLE;
   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);

   logic [PADDR_W-1:0] phys_base_ff;
   mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_wbit;
   logic               mem_rdata;
   entry_kind_type     unit_kind;
   logic [IDX_W-1:0]   unit_idx;
   logic [PADDR_W-1:0] unit_paddr;
   logic [ATTR_W-1:0]  unit_attr;
   logic               unit_busy;
   logic [VADDR_W-1:0] rsp_vaddr;

   // hold phys_base
   always_ff @(posedge clock) begin
      if (reset) begin
         phys_base_ff <= PHYS_BASE_RESET;
      end else if (csr_we) begin
         phys_base_ff <= csr_wdata;
      end
   end

   pgalloc_seq #(
      .NUM_PROCS         (NUM_PROCS),
      .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
      .ADDR_W            (ADDR_W),
      .IDX_W             (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_pid    (req_tdata[2:0]),
      .req_size   (req_tdata[24:3]),
      .req_vaddr  (req_tdata[45:25]),
      .req_paddr  (req_tdata[81:46]),
      .req_attr   (req_tdata[93:82]),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wbit   (mem_wbit),
      .mem_rdata  (mem_rdata),
      .unit_kind  (unit_kind),
      .unit_idx   (unit_idx),
      .unit_paddr (unit_paddr),
      .unit_attr  (unit_attr),
      .unit_busy  (unit_busy),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_vaddr  (rsp_vaddr),
      .rsp_status (rsp_tuser)
   );

   pgalloc_unit #(
      .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
      .IDX_W             (IDX_W)
   ) u_unit (
      .kind      (unit_kind),
      .idx       (unit_idx),
      .phys_base (phys_base_ff),
      .paddr     (unit_paddr),
      .attr      (unit_attr),
      .busy      (unit_busy)
   );

   pgalloc_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wbit  (mem_wbit),
      .mem_rdata (mem_rdata)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_vaddr);

   // reset starts the wipe pass, so no item is taken right after it
   a_wipe_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("item taken during the wipe pass");

   // one item in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   // a failed alloc reports address zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("failed alloc with nonzero address");

   // returned addresses are page aligned
   a_page_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PAGE_SHIFT-1:0] == '0)
      else $error("result address not page aligned");

endmodule

// ===== dv/page_run_first_fit_allocator_tb.sv =====
// Self-checking testbench for page_run_first_fit_allocator: directed table, then random
// request mixes under four idle patterns, checked against an in-bench page table predictor.
// Depends on pgalloc_pkg and the allocator RTL only.
module page_run_first_fit_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pgalloc_pkg::*;

   localparam int NPROC = DEF_NUM_PROCS;
   localparam int NENT  = DEF_ENTRIES_PER_TABLE;

   // unused action codes, answered with a plain done
   localparam logic [ACTION_W-1:0] ACT_RSVD5 = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

   localparam logic STAT_DONE     = 1'b0;
   localparam logic STAT_NO_SPACE = 1'b1;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [PID_W-1:0]    pid;
      logic [SIZE_W-1:0]   size;
      logic [VADDR_W-1:0]  vaddr;
      logic [PADDR_W-1:0]  paddr;
      logic [ATTR_W-1:0]   attr;
   } page_req_type;

   typedef struct {
      logic [VADDR_W-1:0] vaddr;
      logic               status;
   } alloc_reply_type;

   // a run handed out by alloc and not yet freed or cleared
   typedef struct {
      logic [PID_W-1:0] pid;
      int               first;
      int               pages;
   } live_run_type;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   // directed row: a request or a phys_base write (value in paddr)
   typedef struct {
      row_kind_type    kind;
      page_req_type    req;
      bit              typed;
      alloc_reply_type reply;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [PADDR_W-1:0]    csr_wdata = '0;

   // predictor state
   logic [PADDR_W-1:0] page_tbl [NPROC*NENT];
   logic [PADDR_W-1:0] phys_base_q;

   alloc_reply_type replies_due[$];
   live_run_type    live_runs[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int n_requests = 0;
   int n_granted = 0;
   int n_refused = 0;
   int n_base_writes = 0;
   int n_checked = 0;
   int n_errors = 0;

   stim_row_type stim_rows [28] = '{
      // empty tables, reset base
      '{ROW_ITEM, '{ACT_ALLOC, 3'd0, 22'd0, 21'h0, 36'h0, 12'h000}, 1, '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd0, 22'd1, 21'h1FFFFF, 36'h0, 12'hFFF}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd0, 22'd4096, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h1000, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd0, 22'd4097, 21'h0, 36'h0, 12'h800}, 1,
        '{21'h2000, STAT_DONE}},
      // whole table, then nothing left
      '{ROW_ITEM, '{ACT_ALLOC, 3'd1, 22'd2097152, 21'h0, 36'h0, 12'h001}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd1, 22'd1, 21'h0, 36'h0, 12'h001}, 1,
        '{21'h0, STAT_NO_SPACE}},
      // larger than a table
      '{ROW_ITEM, '{ACT_ALLOC, 3'd2, 22'd2097153, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h0, STAT_NO_SPACE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd2, 22'h3FFFFF, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h0, STAT_NO_SPACE}},
      // free running past the last entry frees only the last one
      '{ROW_ITEM, '{ACT_FREE, 3'd1, 22'd12288, 21'h1FF000, 36'h0, 12'h000}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd1, 22'd8192, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h0, STAT_NO_SPACE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd1, 22'd4096, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h1FF000, STAT_DONE}},
      // unmap opens a hole that the next alloc takes
      '{ROW_ITEM, '{ACT_UNMAP, 3'd0, 22'd0, 21'h001FFF, 36'h0, 12'h000}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd0, 22'd100, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h1000, STAT_DONE}},
      // map with all-ones address; a map that writes zero leaves the entry free
      '{ROW_ITEM, '{ACT_MAP, 3'd3, 22'd0, 21'h0, 36'hF_FFFF_FFFF, 12'h000}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_MAP, 3'd3, 22'd0, 21'h1FFFFF, 36'h0_0000_0FFF, 12'h000}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd3, 22'd2093056, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h1000, STAT_DONE}},
      '{ROW_ITEM, '{ACT_CLEAR, 3'd1, 22'd0, 21'h0, 36'h0, 12'h000}, 1, '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd1, 22'd2097152, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h0, STAT_DONE}},
      // unused code with every field at its top
      '{ROW_ITEM, '{ACT_RSVD5, 3'd7, 22'h3FFFFF, 21'h1FFFFF, 36'hF_FFFF_FFFF, 12'hFFF}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_FREE, 3'd0, 22'd0, 21'h0, 36'h0, 12'h000}, 1, '{21'h0, STAT_DONE}},
      // top base: entry one wraps to zero and stays free
      '{ROW_CSR, '{ACT_ALLOC, 3'd0, 22'd0, 21'h0, 36'hF_FFFF_F000, 12'h000}, 0,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd4, 22'd12288, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd4, 22'd1, 21'h0, 36'h0, 12'h000}, 1,
        '{21'h1000, STAT_DONE}},
      // zero base: entry zero with no attributes stays free
      '{ROW_CSR, '{ACT_ALLOC, 3'd0, 22'd0, 21'h0, 36'h0, 12'h000}, 0, '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd5, 22'd1, 21'h0, 36'h0, 12'h000}, 1, '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd5, 22'd1, 21'h0, 36'h0, 12'h000}, 1, '{21'h0, STAT_DONE}},
      // free a two-page run inside a table and allocate it again
      '{ROW_ITEM, '{ACT_FREE, 3'd0, 22'd5000, 21'h002000, 36'h0, 12'h000}, 0,
        '{21'h0, STAT_DONE}},
      '{ROW_ITEM, '{ACT_ALLOC, 3'd0, 22'd8192, 21'h0, 36'h0, 12'h3C3}, 0,
        '{21'h0, STAT_DONE}}
   };

   page_run_first_fit_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one request to the predicted page tables and return its reply.
   task automatic apply_page_action(input page_req_type rq, output alloc_reply_type rep);
      int base, npg, idx, start, run, i;
      bit found;
      base = int'(rq.pid) * NENT;
      npg = (int'(rq.size) + 4095) >>> PAGE_SHIFT;
      idx = int'(rq.vaddr >> PAGE_SHIFT) % NENT;
      rep.vaddr = '0;
      rep.status = STAT_DONE;
      case (rq.action)
         ACT_ALLOC: begin
            // first fit: lowest start of npg zero entries
            found = (npg == 0);
            start = 0;
            run = 0;
            for (i = 0; i < NENT && !found; i++) begin
               if (page_tbl[base+i] == '0) begin
                  run++;
                  if (run == npg) begin
                     found = 1'b1;
                     start = i + 1 - npg;
                  end
               end else begin
                  run = 0;
               end
            end
            if (found) begin
               for (i = 0; i < npg; i++) begin
                  page_tbl[base+start+i] = (phys_base_q + (PADDR_W'(start + i) << PAGE_SHIFT))
                                           | PADDR_W'(rq.attr);
               end
               rep.vaddr = VADDR_W'(start << PAGE_SHIFT);
            end else begin
               rep.status = STAT_NO_SPACE;
            end
         end
         ACT_FREE: begin
            for (i = 0; i < npg && idx + i < NENT; i++) page_tbl[base+idx+i] = '0;
         end
         ACT_MAP: begin
            page_tbl[base+idx] = {rq.paddr[PADDR_W-1:ATTR_W], rq.attr};
         end
         ACT_UNMAP: begin
            page_tbl[base+idx] = '0;
         end
         ACT_CLEAR: begin
            for (i = 0; i < NENT; i++) page_tbl[base+i] = '0;
         end
         default: begin
         end
      endcase
   endtask

   // Drop valid and hold until every reply is back; always advances at least one edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   task automatic write_phys_base(input logic [PADDR_W-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      phys_base_q = value;
      n_base_writes++;
   endtask

   // Present one item after a random gap and hold it until accepted.
   task automatic push_request(input page_req_type rq);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rq.action;
      req_tdata <= {2'b00, rq.attr, rq.paddr, rq.vaddr, rq.size, rq.pid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Send, predict, track live runs and queue the expected reply.
   task automatic issue_request(input page_req_type rq, input bit typed,
                                input alloc_reply_type typed_reply);
      alloc_reply_type got;
      int npg, i;
      push_request(rq);
      apply_page_action(rq, got);
      n_requests++;
      npg = (int'(rq.size) + 4095) >>> PAGE_SHIFT;
      if (rq.action == ACT_ALLOC) begin
         if (got.status == STAT_NO_SPACE) begin
            n_refused++;
         end else begin
            n_granted++;
            if (npg > 0) live_runs.push_back('{rq.pid, int'(got.vaddr >> PAGE_SHIFT), npg});
         end
      end else if (rq.action == ACT_CLEAR) begin
         for (i = live_runs.size() - 1; i >= 0; i--) begin
            if (live_runs[i].pid == rq.pid) live_runs.delete(i);
         end
      end
      replies_due.push_back(typed ? typed_reply : got);
   endtask

   // Random request: mostly allocs and frees of live runs, some maps, unmaps, clears and noise.
   task automatic draw_request(output page_req_type rq);
      int roll, pick, npg;
      live_run_type lr;
      rq.action = ACT_ALLOC;
      rq.pid = PID_W'($urandom);
      rq.size = SIZE_W'($urandom_range(0, 2097152));
      rq.vaddr = VADDR_W'($urandom);
      rq.paddr = {4'($urandom), 32'($urandom)};
      rq.attr = ATTR_W'($urandom);
      roll = int'($urandom_range(0, 99));
      if (roll < 45) begin
         pick = int'($urandom_range(0, 19));
         if (pick < 16) begin
            npg = int'($urandom_range(1, 8));
            rq.size = SIZE_W'(npg * 4096 - int'($urandom_range(0, 4095)));
         end else if (pick == 16) begin
            npg = int'($urandom_range(64, 512));
            rq.size = SIZE_W'(npg * 4096 - int'($urandom_range(0, 4095)));
         end else if (pick > 17) begin
            rq.size = SIZE_W'($urandom_range(0, 4096));
         end
      end else if (roll < 70) begin
         rq.action = ACT_FREE;
         if (live_runs.size() != 0 && $urandom_range(0, 4) != 0) begin
            pick = int'($urandom_range(0, live_runs.size() - 1));
            lr = live_runs[pick];
            live_runs.delete(pick);
            rq.pid = lr.pid;
            rq.vaddr = VADDR_W'(lr.first << PAGE_SHIFT) | VADDR_W'($urandom_range(0, 4095));
            rq.size = SIZE_W'(lr.pages * 4096 - int'($urandom_range(0, 4095)));
         end
      end else if (roll < 80) begin
         rq.action = ACT_MAP;
      end else if (roll < 88) begin
         rq.action = ACT_UNMAP;
         if (live_runs.size() != 0) begin
            lr = live_runs[$urandom_range(0, live_runs.size() - 1)];
            rq.pid = lr.pid;
            rq.vaddr = VADDR_W'((lr.first + int'($urandom_range(0, lr.pages - 1)))
                                << PAGE_SHIFT) | VADDR_W'($urandom_range(0, 4095));
         end
      end else if (roll < 93) begin
         rq.action = ACT_CLEAR;
      end else begin
         rq.action = ACT_RSVD5 + ACTION_W'($urandom_range(0, ACT_RSVD7 - ACT_RSVD5));
      end
   endtask

   // Compare each accepted reply with the oldest expectation; stall at random.
   always @(posedge clock) begin
      alloc_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("%0t: unexpected reply alloc_vaddr %h status %0d",
                        $realtime, rsp_tdata[VADDR_W-1:0], rsp_tuser);
         end else begin
            want = replies_due.pop_front();
            n_checked++;
            if (rsp_tdata[VADDR_W-1:0] !== want.vaddr || rsp_tuser !== want.status) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("%0t: reply %0d: vaddr exp %h got %h, status exp %0d got %0d",
                           $realtime, n_checked, want.vaddr, rsp_tdata[VADDR_W-1:0],
                           want.status, rsp_tuser);
            end
         end
      end
      rsp_tready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
   end

   initial begin
      #(30_000_000);
      $display("Timeout with %0d replies outstanding", replies_due.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      page_req_type rq;
      alloc_reply_type none;
      logic [PADDR_W-1:0] base_val;
      int r, ph, k;
      none = '{'0, STAT_DONE};
      for (r = 0; r < NPROC * NENT; r++) page_tbl[r] = '0;
      phys_base_q = PHYS_BASE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR)
            write_phys_base(stim_rows[i].req.paddr);
         else
            issue_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].reply);
      end

      // random phases: no idling, sender idle, receiver stall, both
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: base_val = PADDR_W'($urandom_range(0, 24'hFF_FFFF)) << PAGE_SHIFT;
            1: base_val = 36'hF_FFFF_F000;
            2: base_val = '0;
            default: base_val = PHYS_BASE_RESET;
         endcase
         write_phys_base(base_val);
         send_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 36 : 0;
         recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 36 : 0;
         for (k = 0; k < 125; k++) begin
            // hold off once per phase until the block has emptied
            if (k == 60) wait_drained();
            draw_request(rq);
            issue_request(rq, 1'b0, none);
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      $display("Sent %0d requests over four idle mixes and %0d phys_base settings",
               n_requests, n_base_writes);
      $display("Allocs granted %0d, refused %0d; replies compared %0d, mismatches %0d",
               n_granted, n_refused, n_checked, n_errors);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
